// File: hdl/ftd_pkg.sv
// Package for the FSK tone energy discriminator.
// Holds sample, term and result types, DFT coefficients and the arithmetic helpers.
// No dependencies.
package ftd_pkg;

  localparam int WIN_LEN    = 8;
  localparam int PROD_SHIFT = 7;
  localparam int SUM_SHIFT  = 3;

  typedef logic signed [7:0]  sample_t;
  typedef logic signed [7:0]  coef_t;
  typedef logic signed [7:0]  term_t;
  typedef logic        [14:0] square_t;
  typedef logic signed [15:0] diff_t;

  typedef sample_t sample_win_t [WIN_LEN];
  typedef term_t   term_win_t   [WIN_LEN];

  typedef struct packed {
    term_t re_hi;
    term_t im_hi;
    term_t re_lo;
    term_t im_lo;
  } parts_t;

  localparam coef_t LO_COS [WIN_LEN] = '{
    8'sd127, 8'sd90, 8'sd0, -8'sd90, -8'sd127, -8'sd90, 8'sd0, 8'sd90};
  localparam coef_t LO_SIN [WIN_LEN] = '{
    8'sd0, -8'sd90, -8'sd127, -8'sd90, 8'sd0, 8'sd90, 8'sd127, 8'sd90};
  localparam coef_t HI_COS [WIN_LEN] = '{
    8'sd127, 8'sd16, -8'sd123, -8'sd49, 8'sd110, 8'sd77, -8'sd90, -8'sd101};
  localparam coef_t HI_SIN [WIN_LEN] = '{
    8'sd0, -8'sd126, -8'sd33, 8'sd117, 8'sd63, -8'sd101, -8'sd90, 8'sd77};

  // Q7 product, floored
  function automatic term_t scaled_product(sample_t s, coef_t c);
    logic signed [15:0] p;
    logic signed [15:0] sh;
    p  = s * c;
    sh = p >>> PROD_SHIFT;
    return sh[7:0];
  endfunction

  // Sum of eight terms, floored by the window scale
  function automatic term_t scaled_sum(term_win_t t);
    logic signed [10:0] acc;
    logic signed [10:0] sh;
    acc = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      acc = acc + {{3{t[i][7]}}, t[i]};
    end
    sh = acc >>> SUM_SHIFT;
    return sh[7:0];
  endfunction

  function automatic square_t square(term_t x);
    logic signed [15:0] p;
    p = x * x;
    return p[14:0];
  endfunction

endpackage

// File: hdl/ftd_channels.sv
// Channel interfaces of the FSK tone energy discriminator.
// Window channel carries eight samples, result channel one tone difference.
// Depends on ftd_pkg.
interface ftd_win_if import ftd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  sample_t sample_4;
  sample_t sample_5;
  sample_t sample_6;
  sample_t sample_7;

  modport source (output valid, output sample_0, output sample_1, output sample_2,
                  output sample_3, output sample_4, output sample_5, output sample_6,
                  output sample_7, input ready);
  modport sink (input valid, input sample_0, input sample_1, input sample_2,
                input sample_3, input sample_4, input sample_5, input sample_6,
                input sample_7, output ready);
endinterface

interface ftd_res_if import ftd_pkg::*; ();
  logic  valid;
  logic  ready;
  diff_t tone_difference;

  modport source (output valid, output tone_difference, input ready);
  modport sink (input valid, input tone_difference, output ready);
endinterface

// File: hdl/ftd_front.sv
// Front part: accepts a window, forms the scaled Q7 products and the scaled DFT sums.
// Two elastic stages; hands the four scaled parts to the queue.
// Depends on ftd_pkg and ftd_win_if.
module ftd_front import ftd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ftd_win_if.sink  window,
  output logic     push_valid,
  input  logic     push_ready,
  output parts_t   push_parts
);

  sample_win_t s;
  term_win_t   re_hi_next, im_hi_next, re_lo_next, im_lo_next;
  term_win_t   re_hi, im_hi, re_lo, im_lo;
  logic        v1, v2;
  logic        ready1, ready2;
  parts_t      parts;

  assign s[0] = window.sample_0;
  assign s[1] = window.sample_1;
  assign s[2] = window.sample_2;
  assign s[3] = window.sample_3;
  assign s[4] = window.sample_4;
  assign s[5] = window.sample_5;
  assign s[6] = window.sample_6;
  assign s[7] = window.sample_7;

  assign ready2       = !v2 || push_ready;
  assign ready1       = !v1 || ready2;
  assign window.ready = ready1;

  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      re_hi_next[i] = scaled_product(s[i], HI_COS[i]);
      im_hi_next[i] = scaled_product(s[i], HI_SIN[i]);
      re_lo_next[i] = scaled_product(s[i], LO_COS[i]);
      im_lo_next[i] = scaled_product(s[i], LO_SIN[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= window.valid;
      if (ready2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && window.valid) begin
      re_hi <= re_hi_next;
      im_hi <= im_hi_next;
      re_lo <= re_lo_next;
      im_lo <= im_lo_next;
    end
    if (ready2 && v1) begin
      parts.re_hi <= scaled_sum(re_hi);
      parts.im_hi <= scaled_sum(im_hi);
      parts.re_lo <= scaled_sum(re_lo);
      parts.im_lo <= scaled_sum(im_lo);
    end
  end

  assign push_valid = v2;
  assign push_parts = parts;

endmodule

// File: hdl/ftd_queue.sv
// Short queue between front and back parts.
// Holds scaled DFT parts; full and empty come from a registered fill count.
// Depends on ftd_pkg.
module ftd_queue import ftd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  parts_t push_parts,
  output logic   pop_valid,
  input  logic   pop_ready,
  output parts_t pop_parts
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  parts_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_parts  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_parts;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/ftd_back.sv
// Back part: squares the scaled parts, adds them into tone energies and subtracts.
// Square stage then output register; drives the result channel.
// Depends on ftd_pkg and ftd_res_if.
module ftd_back import ftd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  parts_t   pop_parts,
  ftd_res_if.source result
);

  logic        vb, vo;
  logic        ready_b, ready_o;
  square_t     sq_re_hi, sq_im_hi, sq_re_lo, sq_im_lo;
  logic [15:0] e_hi, e_lo;
  logic signed [16:0] diff;
  diff_t       tone_difference;

  assign ready_o   = !vo || result.ready;
  assign ready_b   = !vb || ready_o;
  assign pop_ready = ready_b;

  assign e_hi = {1'b0, sq_re_hi} + {1'b0, sq_im_hi};
  assign e_lo = {1'b0, sq_re_lo} + {1'b0, sq_im_lo};
  assign diff = $signed({1'b0, e_hi}) - $signed({1'b0, e_lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (ready_b) vb <= pop_valid;
      if (ready_o) vo <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && pop_valid) begin
      sq_re_hi <= square(pop_parts.re_hi);
      sq_im_hi <= square(pop_parts.im_hi);
      sq_re_lo <= square(pop_parts.re_lo);
      sq_im_lo <= square(pop_parts.im_lo);
    end
    if (ready_o && vb) tone_difference <= diff[15:0];
  end

  assign result.valid           = vo;
  assign result.tone_difference = tone_difference;

endmodule

// File: hdl/fsk_tone_energy_discriminator_top.sv
// FSK tone energy discriminator, top level.
// Window channel in: eight signed 8-bit samples per transfer, sample_0 oldest.
// Result channel out: tone_difference, 2200 Hz energy minus 1200 Hz energy.
// Throughput: one window per cycle while nothing stalls, set by the two-stage
// front (products, sums) and the two-stage back (squares, energy difference),
// each fully pipelined. A window passes the product, sum, queue, square and
// output registers in that order before its result shows on the result channel.
// Front and back are parted by a queue of QUEUE_DEPTH entries; a stalled result
// receiver fills the back stages, then the queue and then the front stages, and
// only then does the window channel drop ready. Results keep their value while
// stalled.
// Reset clears all valid flags, the queue pointers and the queue count, and the
// block is ready for a window in the first cycle after reset.
// Depends on ftd_pkg, ftd_channels, ftd_front, ftd_queue and ftd_back.
module fsk_tone_energy_discriminator_top import ftd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  ftd_win_if.sink   window,
  ftd_res_if.source result
);

  logic   push_valid, push_ready, pop_valid, pop_ready;
  parts_t push_parts, pop_parts;

  ftd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .window     (window),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_parts (push_parts)
  );

  ftd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_parts (push_parts),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_parts  (pop_parts)
  );

  ftd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_parts (pop_parts),
    .result    (result)
  );

endmodule

// File: hdl/ftd_checker.sv
// Port-level checks for the FSK tone energy discriminator, bound to the top level.
// Tracks windows in flight against results delivered.
// Depends on ftd_pkg.
module ftd_checker import ftd_pkg::*; #(
  parameter int CAPACITY = 6
) (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input diff_t out_data
);

  logic [7:0] outstanding;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {7'd0, in_xfer} - {7'd0, out_xfer};
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 8'd0)
    else $error("result without an accepted window");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 8'(CAPACITY))
    else $error("more windows in flight than the pipeline holds");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind fsk_tone_energy_discriminator_top ftd_checker #(.CAPACITY(QUEUE_DEPTH + 4)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (window.valid),
  .in_ready  (window.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.tone_difference)
);
